// ----- rtl/assert_macros.svh -----
// assertion macros used by the scanner top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/pcs_pkg.sv -----
// types and constants of the png animation chunk scanner
package pcs_pkg;

  // verdict causes
  typedef enum logic [1:0] {
    CAUSE_ACTL        = 2'd0,
    CAUSE_BAD_SIG     = 2'd1,
    CAUSE_IMAGE_FIRST = 2'd2,
    CAUSE_EOF         = 2'd3
  } pcs_cause_t;

  // chunk type codes, big-endian ascii
  localparam logic [31:0] TYPE_ACTL = 32'h6163_544C;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // crc bytes that follow every chunk's data
  localparam logic [32:0] CRC_BYTES = 33'd4;

  localparam logic [2:0] LAST_IDX = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } pcs_item_t;

  typedef struct packed {
    logic       valid;
    logic       has_animation;
    pcs_cause_t cause;
  } pcs_verdict_t;

  // expected png signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'd137;
      3'd1: val = 8'd80;
      3'd2: val = 8'd78;
      3'd3: val = 8'd71;
      3'd4: val = 8'd13;
      3'd5: val = 8'd10;
      3'd6: val = 8'd26;
      3'd7: val = 8'd10;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/pcs_scan.sv -----
// scan state machine: signature check, chunk header parse, data skip
module pcs_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  pcs_pkg::pcs_item_t    item,
  output pcs_pkg::pcs_verdict_t verdict
);

  typedef enum logic [1:0] {PH_SIG, PH_HDR, PH_SKIP, PH_DONE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        bad_r, bad_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [32:0] skip_r, skip_nxt;

  always_comb begin
    phase_t      ph;
    logic [2:0]  idx;
    logic        bad;
    logic [31:0] len;
    logic [31:0] typ;
    logic [32:0] skip;
    logic [32:0] skip_dec;

    // a first byte restarts the scan from the reset state
    ph   = item.first_byte ? PH_SIG : phase_r;
    idx  = item.first_byte ? 3'd0   : idx_r;
    bad  = item.first_byte ? 1'b0   : bad_r;
    len  = item.first_byte ? 32'd0  : len_r;
    typ  = item.first_byte ? 32'd0  : type_r;
    skip = item.first_byte ? 33'd0  : skip_r;

    phase_nxt = ph;
    idx_nxt   = idx;
    bad_nxt   = bad;
    len_nxt   = len;
    type_nxt  = typ;
    skip_nxt  = skip;
    skip_dec  = skip;

    verdict.valid         = 1'b0;
    verdict.has_animation = 1'b0;
    verdict.cause         = pcs_pkg::CAUSE_EOF;

    unique case (ph)
      PH_SIG: begin
        bad_nxt = bad | (item.data_byte != pcs_pkg::sig_byte(idx));
        if (idx == pcs_pkg::LAST_IDX) begin
          idx_nxt = 3'd0;
          if (bad_nxt) begin
            verdict.valid = 1'b1;
            verdict.cause = pcs_pkg::CAUSE_BAD_SIG;
          end else begin
            phase_nxt = PH_HDR;
          end
        end else begin
          idx_nxt = idx + 3'd1;
        end
      end
      PH_HDR: begin
        if (!idx[2]) begin
          len_nxt = {len[23:0], item.data_byte};
        end else begin
          type_nxt = {typ[23:0], item.data_byte};
        end
        if (idx == pcs_pkg::LAST_IDX) begin
          idx_nxt = 3'd0;
          if (type_nxt == pcs_pkg::TYPE_ACTL) begin
            verdict.valid = 1'b1;
            verdict.cause = pcs_pkg::CAUSE_ACTL;
          end else if (type_nxt == pcs_pkg::TYPE_IDAT || type_nxt == pcs_pkg::TYPE_IEND) begin
            verdict.valid = 1'b1;
            verdict.cause = pcs_pkg::CAUSE_IMAGE_FIRST;
          end else begin
            skip_nxt  = {1'b0, len_nxt} + pcs_pkg::CRC_BYTES;
            phase_nxt = PH_SKIP;
          end
        end else begin
          idx_nxt = idx + 3'd1;
        end
      end
      PH_SKIP: begin
        if (skip != 33'd0) begin
          skip_dec = skip - 33'd1;
        end
        skip_nxt = skip_dec;
        if (skip_dec == 33'd0) begin
          phase_nxt = PH_HDR;
          idx_nxt   = 3'd0;
        end
      end
      PH_DONE: begin
        // bytes after the verdict are dropped
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (ph != PH_DONE && !verdict.valid && item.end_of_file) begin
      verdict.valid = 1'b1;
      verdict.cause = pcs_pkg::CAUSE_EOF;
    end
    if (verdict.valid) begin
      phase_nxt = PH_DONE;
    end
    verdict.has_animation = verdict.valid && (verdict.cause == pcs_pkg::CAUSE_ACTL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      idx_r   <= 3'd0;
      bad_r   <= 1'b0;
      len_r   <= 32'd0;
      type_r  <= 32'd0;
      skip_r  <= 33'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      bad_r   <= bad_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

// ----- rtl/png_animation_chunk_scanner.sv -----
// png animation chunk scanner top level: input register, scan logic, result register
//
// Takes a file one byte per item and gives one verdict per file: whether an
// animation control chunk (acTL) appears before the first IDAT or IEND chunk.
// first_byte restarts the scan; end_of_file on a byte that gives no other
// verdict yields cause 3 (file ended). cause: 0 acTL found, 1 bad signature,
// 2 image or end chunk reached first, 3 file ended; has_animation is 1 only
// with cause 0. Bytes after the verdict are dropped without a result until
// the next first_byte. The block takes one byte per cycle back to back
// while no result waits unread; an item passes an input register, then
// one pass of the scan logic into the result register, where its verdict
// is registered. Both registers advance together whenever the result
// register is empty or being taken; while a result waits unread the input
// register still takes one more item, then in_ready drops.
`include "assert_macros.svh"

module png_animation_chunk_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_end_of_file,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_animation,
  output logic [1:0] out_cause
);

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  pcs_pkg::pcs_item_t s1_item_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 has_anim_r;
  pcs_pkg::pcs_cause_t  cause_r;

  pcs_pkg::pcs_verdict_t verdict;
  logic                  advance;
  logic                  in_fire;
  logic                  s1_step;

  // terms for the checks at the end
  logic hold_s1;
  logic one_byte;
  logic anim_ok;
  logic eof_out;

  // the pipe moves when the result slot is free or being emptied
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;
  assign s1_step  = advance && s1_valid_r;

  pcs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_step),
    .item    (s1_item_r),
    .verdict (verdict)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (advance) begin
      // only items that reach a verdict load a result
      out_valid_nxt = s1_valid_r && verdict.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte   <= in_data_byte;
      s1_item_r.first_byte  <= in_first_byte;
      s1_item_r.end_of_file <= in_end_of_file;
    end
    if (s1_step && verdict.valid) begin
      has_anim_r <= verdict.has_animation;
      cause_r    <= verdict.cause;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_animation = has_anim_r;
  assign out_cause         = cause_r;

  assign hold_s1  = !advance && s1_valid_r;
  assign one_byte = s1_step && s1_item_r.first_byte && s1_item_r.end_of_file;
  assign anim_ok  = has_anim_r == (cause_r == pcs_pkg::CAUSE_ACTL);
  assign eof_out  = out_valid_r && (cause_r == pcs_pkg::CAUSE_EOF);

  // a blocked result holds the staged item in place
  `ASSERT_CLK(a_stage_hold, clk, rst_n, hold_s1 |=> s1_valid_r && $stable(s1_item_r), "stage not held")

  // has_animation goes with the acTL cause and nothing else
  `ASSERT_NEVER(a_anim_cause, clk, rst_n, out_valid_r && !anim_ok, "anim flag vs cause")

  // a one-byte file always ends with the file-ended cause
  `ASSERT_CLK(a_one_byte_file, clk, rst_n, one_byte |=> eof_out, "one-byte file verdict")

endmodule

// ----- tb/scan_verdict_checker.sv -----
// checker for the png animation chunk scanner: predicts each file's verdict and compares
`timescale 1ns / 100ps

module scan_verdict_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_end_of_file,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_has_animation,
  input  logic [1:0] out_cause,
  input  logic       run_done,
  output int         fail_count,
  output int         expected_left
);

  // png signature, first byte in the top bits
  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;

  typedef enum logic [1:0] {
    SCAN_SIG,
    SCAN_HDR,
    SCAN_SKIP,
    SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic                has_animation;
    pcs_pkg::pcs_cause_t cause;
  } verdict_t;

  scan_phase_t scan_phase;
  logic [2:0]  pos;
  logic        sig_mismatch;
  logic [31:0] len_field;
  logic [31:0] type_field;
  logic [32:0] skip_left;

  verdict_t awaited_verdicts[$];
  verdict_t seen_want;
  verdict_t new_verdict;

  initial begin
    fail_count = 0;
    expected_left = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] verdict mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void restart_scan();
    scan_phase   = SCAN_SIG;
    pos          = '0;
    sig_mismatch = 1'b0;
    len_field    = '0;
    type_field   = '0;
    skip_left    = '0;
  endfunction

  // one file byte through the scan; returns 1 when it settles the file
  function automatic bit scan_byte(input logic [7:0] b, input logic first, input logic last,
                                   output verdict_t v);
    bit                  decided;
    pcs_pkg::pcs_cause_t why;
    decided = 1'b0;
    why     = pcs_pkg::CAUSE_EOF;
    if (first) restart_scan();
    if (scan_phase == SCAN_DONE) return 1'b0;
    unique case (scan_phase)
      SCAN_SIG: begin
        if (b != PNG_MAGIC[63 - 8 * int'(pos) -: 8]) sig_mismatch = 1'b1;
        if (pos == 3'd7) begin
          pos = '0;
          if (sig_mismatch) begin
            decided = 1'b1;
            why     = pcs_pkg::CAUSE_BAD_SIG;
          end else begin
            scan_phase = SCAN_HDR;
          end
        end else begin
          pos++;
        end
      end
      SCAN_HDR: begin
        if (pos < 3'd4) len_field = {len_field[23:0], b};
        else type_field = {type_field[23:0], b};
        if (pos == 3'd7) begin
          pos = '0;
          if (type_field == pcs_pkg::TYPE_ACTL) begin
            decided = 1'b1;
            why     = pcs_pkg::CAUSE_ACTL;
          end else if (type_field == pcs_pkg::TYPE_IDAT ||
                       type_field == pcs_pkg::TYPE_IEND) begin
            decided = 1'b1;
            why     = pcs_pkg::CAUSE_IMAGE_FIRST;
          end else begin
            // 33 bits so a length near the top never wraps
            skip_left  = {1'b0, len_field} + pcs_pkg::CRC_BYTES;
            scan_phase = SCAN_SKIP;
          end
        end else begin
          pos++;
        end
      end
      default: begin
        if (skip_left != '0) skip_left--;
        if (skip_left == '0) begin
          scan_phase = SCAN_HDR;
          pos        = '0;
        end
      end
    endcase
    if (!decided && last) begin
      decided = 1'b1;
      why     = pcs_pkg::CAUSE_EOF;
    end
    if (decided) begin
      scan_phase      = SCAN_DONE;
      v.has_animation = (why == pcs_pkg::CAUSE_ACTL);
      v.cause         = why;
    end
    return decided;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_scan();
      awaited_verdicts.delete();
    end else begin
      // compare before predicting so a stray verdict is never matched early
      if (out_valid && out_ready) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict with none pending, cause %0d", out_cause));
        end else begin
          seen_want = awaited_verdicts.pop_front();
          if (out_has_animation !== seen_want.has_animation)
            report_mismatch($sformatf("has_animation %b, want %b",
                                      out_has_animation, seen_want.has_animation));
          if (out_cause !== seen_want.cause)
            report_mismatch($sformatf("cause %0d, want %0d", out_cause, seen_want.cause));
        end
      end
      if (in_valid && in_ready) begin
        if (scan_byte(in_data_byte, in_first_byte, in_end_of_file, new_verdict))
          awaited_verdicts.push_back(new_verdict);
      end
    end
    expected_left = awaited_verdicts.size();
  end

  always @(posedge run_done) begin
    if (awaited_verdicts.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", awaited_verdicts.size()));
  end

endmodule

// ----- tb/tb_png_animation_chunk_scanner.sv -----
// testbench top for the png animation chunk scanner: file stimulus, handshake pacing, verdict
`timescale 1ns / 100ps

module tb_png_animation_chunk_scanner;

  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
  localparam int STALL_LIMIT     = 2000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES    = 8;     // wait after the last verdict before run_done
  localparam int TARGET_BYTES    = 1400;
  localparam int TARGET_VERDICTS = 48;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_first_byte;
  logic       in_end_of_file;
  logic       out_valid;
  logic       out_ready;
  logic       out_has_animation;
  logic [1:0] out_cause;

  logic run_done;
  int   fail_count;
  int   expected_left;

  // receiver hold-off requests, served by the receiver process
  int holds_asked   = 0;
  int holds_done    = 0;
  int verdicts_seen = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int bytes_sent    = 0;

  // file under construction
  logic [7:0] file_q[$];
  int         eof_at;
  int         trail_len;
  bit         with_first;

  png_animation_chunk_scanner u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_has_animation (out_has_animation),
    .out_cause         (out_cause)
  );

  scan_verdict_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_has_animation (out_has_animation),
    .out_cause         (out_cause),
    .run_done          (run_done),
    .fail_count        (fail_count),
    .expected_left     (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // verdicts taken so far, only used to decide when random files stop
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) verdicts_seen <= verdicts_seen + 1;
  end

  // watchdog: ends the run when neither channel moves an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stretches of always-ready, coin-flip, one-in-four and mostly-stalled,
  // plus the long hold-off whenever the stimulus asks for one
  initial begin : receiver
    int mode;
    int stretch;
    int tick;
    out_ready = 1'b0;
    tick = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        @(negedge clk);
        if (holds_asked != holds_done) begin
          holds_done++;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (tick % 4 == 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        tick++;
      end
    end
  end

  // offer one byte; called and returning at a falling edge
  task automatic offer_byte(input logic [7:0] b, input logic first, input logic last);
    int gap;
    // sender works in bursts, a random gap opens each new burst
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_first_byte  <= first;
    in_end_of_file <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic push_header(input logic [31:0] len, input logic [31:0] typ);
    file_q.push_back(len[31:24]);
    file_q.push_back(len[23:16]);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    file_q.push_back(typ[31:24]);
    file_q.push_back(typ[23:16]);
    file_q.push_back(typ[15:8]);
    file_q.push_back(typ[7:0]);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++)
      offer_byte(file_q[i], with_first && i == 0, i == eof_at);
  endtask

  // one-byte file, first and last on the same item
  task automatic tiny_file();
    file_q.delete();
    file_q.push_back(8'($urandom));
    with_first = 1'b1;
    eof_at     = 0;
    trail_len  = 0;
  endtask

  // mostly well-formed files with random content; some noise and short files
  task automatic build_file();
    int          kind;
    int          nchunks;
    int          term;
    int          i;
    int          k;
    int          r;
    logic [31:0] len;
    logic [31:0] typ;
    bit          cut;
    file_q.delete();
    with_first = 1'b1;
    trail_len  = 0;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      tiny_file();
      return;
    end
    if (kind < 14) begin
      // noise, sometimes continuing the previous file
      repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
      with_first = ($urandom_range(0, 3) != 0);
      eof_at = ($urandom_range(0, 1) != 0) ? file_q.size() - 1 : -1;
      return;
    end
    for (i = 0; i < 8; i++) file_q.push_back(pcs_pkg::sig_byte(3'(i)));
    // occasional single-bit hit in the signature
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, 7);
      file_q[k] = file_q[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    cut = 1'b0;
    nchunks = $urandom_range(0, 3);
    for (i = 0; i < nchunks && !cut; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        // huge length: near the 32-bit top so length plus crc crosses it, or top bit set
        len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                          : ($urandom | 32'h8000_0000);
        cut = 1'b1;
      end else begin
        len = $urandom_range(0, 12);
      end
      r = $urandom_range(0, 9);
      if (r < 2) begin
        // one bit away from a type that matters
        case ($urandom_range(0, 2))
          0: typ = pcs_pkg::TYPE_ACTL;
          1: typ = pcs_pkg::TYPE_IDAT;
          default: typ = pcs_pkg::TYPE_IEND;
        endcase
        typ = typ ^ (32'd1 << $urandom_range(0, 31));
      end else if (r < 4) begin
        typ = $urandom;
      end else begin
        typ = {8'($urandom_range(65, 122)), 8'($urandom_range(65, 122)),
               8'($urandom_range(65, 122)), 8'($urandom_range(65, 122))};
      end
      push_header(len, typ);
      if (cut) repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom));
      else repeat (len + 4) file_q.push_back(8'($urandom));
    end
    if (!cut) begin
      term = $urandom_range(0, 3);
      if (term < 3) begin
        case (term)
          0: typ = pcs_pkg::TYPE_ACTL;
          1: typ = pcs_pkg::TYPE_IDAT;
          default: typ = pcs_pkg::TYPE_IEND;
        endcase
        push_header($urandom, typ);
        // bytes past the verdict, ignored by the block
        trail_len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 5);
        repeat (trail_len) file_q.push_back(8'($urandom));
      end
    end
    r = $urandom_range(0, 9);
    if (r < 7) begin
      eof_at = file_q.size() - 1;
    end else if (r < 9) begin
      // truncated file, ends anywhere
      eof_at    = $urandom_range(0, file_q.size() - 1);
      file_q    = file_q[0:eof_at];
      trail_len = 0;
    end else begin
      eof_at = -1;
    end
  endtask

  initial begin : stimulus
    int i;
    int file_no;
    rst_n          = 1'b0;
    run_done       = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_first_byte  = 1'b0;
    in_end_of_file = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes before any first byte: scanned as a file that began at reset
    offer_byte(8'd137, 1'b0, 1'b0);
    offer_byte(8'd80, 1'b0, 1'b0);
    offer_byte(8'h00, 1'b0, 1'b0);
    // one-byte file, first and last together: file ended
    offer_byte(8'hFF, 1'b1, 1'b1);
    // all-zero signature, rejected on its eighth byte
    for (i = 0; i < 8; i++) offer_byte(8'h00, i == 0, 1'b0);
    // after the verdict, bytes are dropped, the last-byte mark too
    offer_byte(8'hFF, 1'b0, 1'b0);
    offer_byte(8'h5A, 1'b0, 1'b1);
    // clean signature and nothing after it
    for (i = 0; i < 8; i++) offer_byte(pcs_pkg::sig_byte(3'(i)), i == 0, i == 7);

    file_no = 0;
    while (bytes_sent < TARGET_BYTES || verdicts_seen < TARGET_VERDICTS) begin
      if (file_no == 12 || file_no == 38) begin
        // receiver holds off while short files keep coming: the block fills
        // its result and input registers and must stall its input
        holds_asked++;
        repeat (6) begin
          tiny_file();
          send_file();
          bytes_sent++;
        end
      end
      if (file_no == 25 || file_no == 50) begin
        // sender pauses until every pending verdict is out
        in_valid <= 1'b0;
        @(negedge clk);
        wait (expected_left == 0);
        @(negedge clk);
        burst_left = 0;
      end
      build_file();
      send_file();
      bytes_sent += file_q.size() - trail_len;
      file_no++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    wait (expected_left == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    run_done = 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
